@@ rtl/ibd_pkg.sv @@
// Shared types and constants for the idle backlight dimmer.
// Holds the item structs, the configuration bundle and the register map.
// No dependencies.
package ibd_pkg;

  localparam int unsigned LevelW   = 8;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned ElapsedW = 10;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 32;

  // Register index, taken from paddr[4:2].
  typedef enum logic [2:0] {
    REG_USER_LEVEL    = 3'd0,
    REG_DIM_TIMEOUT   = 3'd1,
    REG_SLEEP_TIMEOUT = 3'd2,
    REG_DIM_LEVEL     = 3'd3,
    REG_STEP_DOWN     = 3'd4,
    REG_STEP_UP       = 3'd5
  } reg_idx_t;

  localparam logic [LevelW-1:0] UserLevelRst    = 8'd128;
  localparam logic [TimeW-1:0]  DimTimeoutRst   = 32'd30000;
  localparam logic [TimeW-1:0]  SleepTimeoutRst = 32'd60000;
  localparam logic [LevelW-1:0] DimLevelRst     = 8'd20;
  localparam logic [LevelW-1:0] StepDownRst     = 8'd5;
  localparam logic [LevelW-1:0] StepUpRst       = 8'd50;

  typedef struct packed {
    logic                activity;
    logic [ElapsedW-1:0] elapsed_ms;
    logic                playing;
  } tick_t;

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic              dimmed;
    logic              changed;
  } result_t;

  typedef struct packed {
    logic [LevelW-1:0] user_level;
    logic [TimeW-1:0]  dim_timeout;
    logic [TimeW-1:0]  sleep_timeout;
    logic [LevelW-1:0] dim_level;
    logic [LevelW-1:0] step_down;
    logic [LevelW-1:0] step_up;
  } cfg_t;

endpackage

@@ rtl/ibd_regs.sv @@
// Configuration register file for the idle backlight dimmer, APB-style port.
// Depends on ibd_pkg for the register map, reset values and cfg_t.
module ibd_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ibd_pkg::AddrW-1:0]   paddr,
  input  logic [ibd_pkg::DataW-1:0]   pwdata,
  output logic [ibd_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output ibd_pkg::cfg_t               cfg
);

  logic             wr_en;
  ibd_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = ibd_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.user_level    <= ibd_pkg::UserLevelRst;
      cfg.dim_timeout   <= ibd_pkg::DimTimeoutRst;
      cfg.sleep_timeout <= ibd_pkg::SleepTimeoutRst;
      cfg.dim_level     <= ibd_pkg::DimLevelRst;
      cfg.step_down     <= ibd_pkg::StepDownRst;
      cfg.step_up       <= ibd_pkg::StepUpRst;
    end else if (wr_en) begin
      unique case (idx)
        ibd_pkg::REG_USER_LEVEL:    cfg.user_level    <= pwdata[7:0];
        ibd_pkg::REG_DIM_TIMEOUT:   cfg.dim_timeout   <= pwdata;
        ibd_pkg::REG_SLEEP_TIMEOUT: cfg.sleep_timeout <= pwdata;
        ibd_pkg::REG_DIM_LEVEL:     cfg.dim_level     <= pwdata[7:0];
        ibd_pkg::REG_STEP_DOWN:     cfg.step_down     <= pwdata[7:0];
        ibd_pkg::REG_STEP_UP:       cfg.step_up       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ibd_pkg::REG_USER_LEVEL:    prdata = {24'd0, cfg.user_level};
      ibd_pkg::REG_DIM_TIMEOUT:   prdata = cfg.dim_timeout;
      ibd_pkg::REG_SLEEP_TIMEOUT: prdata = cfg.sleep_timeout;
      ibd_pkg::REG_DIM_LEVEL:     prdata = {24'd0, cfg.dim_level};
      ibd_pkg::REG_STEP_DOWN:     prdata = {24'd0, cfg.step_down};
      ibd_pkg::REG_STEP_UP:       prdata = {24'd0, cfg.step_up};
      default:                    prdata = '0;
    endcase
  end

endmodule

@@ rtl/idle_backlight_dimmer_core.sv @@
// Top level of the idle backlight dimmer with slew-rate limited level.
// Depends on ibd_pkg and instantiates ibd_regs for the configuration port.
//
// Usage: every item on the tick channel (tick_valid/tick_ready, payload tick)
// is one tick carrying an activity flag, the milliseconds since the previous
// tick and a playing flag. For each tick the block returns exactly one item
// on the result channel (result_valid/result_ready, payload result) with the
// backlight level, a dimmed flag and a changed flag.
//
// A tick accepted at a rising edge is captured in the input register; its result
// is written to the result register when the input register advances, which
// waits while a stalled receiver keeps the result register full.
// Throughput is one tick per clock while the receiver does not stall. The idle
// counter update, the two timeout compares and the 8-bit slew step sit between
// the input register and the result register; that path sets the clock limit.
//
// When the receiver stalls, the result register holds its item, the input
// register holds the next tick, and tick_ready drops only when both are full.
// Synchronous reset clears both valid flags, the idle counter, the level and
// the started flag, and loads the registers with their reset values. The first
// tick after reset loads the level straight from user_level.
// Configuration is written through the APB-style port; the user must write it
// only while no tick is in flight, which the block itself does not enforce.
module idle_backlight_dimmer_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      tick_valid,
  output logic                      tick_ready,
  input  ibd_pkg::tick_t            tick,
  output logic                      result_valid,
  input  logic                      result_ready,
  output ibd_pkg::result_t          result,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ibd_pkg::AddrW-1:0] paddr,
  input  logic [ibd_pkg::DataW-1:0] pwdata,
  output logic [ibd_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  ibd_pkg::cfg_t cfg;

  ibd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register stage.
  logic           tick_q_valid;
  ibd_pkg::tick_t tick_q;
  logic           advance;

  // Tick state.
  logic [ibd_pkg::TimeW-1:0]  idle_time;
  logic [ibd_pkg::LevelW-1:0] current_level;
  logic                       started;

  // The input register moves on whenever the result register is empty or is
  // being emptied in this cycle, so both stages can stream.
  assign advance    = tick_q_valid && (!result_valid || result_ready);
  assign tick_ready = !tick_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_q_valid <= 1'b0;
    end else if (tick_ready) begin
      tick_q_valid <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_ready && tick_valid) begin
      tick_q <= tick;
    end
  end

  // Step logic for the tick in the input register.
  logic [ibd_pkg::TimeW:0]    idle_sum;
  logic [ibd_pkg::TimeW-1:0]  idle_time_next;
  logic [ibd_pkg::LevelW-1:0] target;
  logic                       dimmed;
  logic [ibd_pkg::LevelW-1:0] step;
  logic [ibd_pkg::LevelW-1:0] gap;
  logic [ibd_pkg::LevelW-1:0] level_next;
  logic                       changed;

  always_comb begin
    // Saturating idle counter; activity clears it.
    idle_sum = {1'b0, idle_time} + {{(ibd_pkg::TimeW + 1 - ibd_pkg::ElapsedW){1'b0}},
                                    tick_q.elapsed_ms};
    if (tick_q.activity) begin
      idle_time_next = '0;
    end else if (idle_sum[ibd_pkg::TimeW]) begin
      idle_time_next = '1;
    end else begin
      idle_time_next = idle_sum[ibd_pkg::TimeW-1:0];
    end

    // The dim compare wins over the sleep compare, even when the sleep
    // timeout is set below the dim timeout.
    if (idle_time_next < cfg.dim_timeout) begin
      dimmed = 1'b0;
      target = cfg.user_level;
    end else if ((idle_time_next < cfg.sleep_timeout) || tick_q.playing) begin
      dimmed = 1'b1;
      target = cfg.dim_level;
    end else begin
      dimmed = 1'b1;
      target = '0;
    end

    // Asymmetric slew; a step register of zero behaves as a step of one.
    if (current_level > target) begin
      step = (cfg.step_down == '0) ? 8'd1 : cfg.step_down;
      gap  = current_level - target;
      level_next = (gap > step) ? current_level - step : target;
    end else begin
      step = (cfg.step_up == '0) ? 8'd1 : cfg.step_up;
      gap  = target - current_level;
      level_next = (gap > step) ? current_level + step : target;
    end
    changed = (current_level != target);

    // The first tick after reset jumps straight to the user level.
    if (!started) begin
      level_next = cfg.user_level;
      changed    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_time     <= '0;
      current_level <= '0;
      started       <= 1'b0;
    end else if (advance) begin
      idle_time     <= idle_time_next;
      current_level <= level_next;
      started       <= 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.level   <= level_next;
      result.dimmed  <= dimmed;
      result.changed <= changed;
    end
  end

endmodule

@@ verif/idle_backlight_dimmer_core_test.sv @@
// Self-checking testbench for idle_backlight_dimmer_core: random and directed ticks,
// with the expected level, dimmed and changed flags predicted cycle-free in a class.
// Depends on ibd_pkg and the RTL of the block; nothing else.
`timescale 1ns / 1ps

// Keeps its own copy of the registers and of the dimmer state, predicts one
// result per accepted tick and checks the results in order.
class backlight_scoreboard;
  ibd_pkg::cfg_t                regs;
  logic [ibd_pkg::TimeW-1:0]    idle_ms;
  logic [ibd_pkg::LevelW-1:0]   backlight;
  bit                           synced;
  ibd_pkg::result_t             awaited[$];
  int unsigned                  errors;
  int unsigned                  checked;
  int unsigned                  dim_seen;
  int unsigned                  change_seen;

  function new();
    regs.user_level    = ibd_pkg::UserLevelRst;
    regs.dim_timeout   = ibd_pkg::DimTimeoutRst;
    regs.sleep_timeout = ibd_pkg::SleepTimeoutRst;
    regs.dim_level     = ibd_pkg::DimLevelRst;
    regs.step_down     = ibd_pkg::StepDownRst;
    regs.step_up       = ibd_pkg::StepUpRst;
    idle_ms     = '0;
    backlight   = '0;
    synced      = 1'b0;
    errors      = 0;
    checked     = 0;
    dim_seen    = 0;
    change_seen = 0;
  endfunction

  function void set_reg(ibd_pkg::reg_idx_t idx, logic [ibd_pkg::DataW-1:0] value);
    case (idx)
      ibd_pkg::REG_USER_LEVEL:    regs.user_level    = value[ibd_pkg::LevelW-1:0];
      ibd_pkg::REG_DIM_TIMEOUT:   regs.dim_timeout   = value[ibd_pkg::TimeW-1:0];
      ibd_pkg::REG_SLEEP_TIMEOUT: regs.sleep_timeout = value[ibd_pkg::TimeW-1:0];
      ibd_pkg::REG_DIM_LEVEL:     regs.dim_level     = value[ibd_pkg::LevelW-1:0];
      ibd_pkg::REG_STEP_DOWN:     regs.step_down     = value[ibd_pkg::LevelW-1:0];
      ibd_pkg::REG_STEP_UP:       regs.step_up       = value[ibd_pkg::LevelW-1:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  // Advances the dimmer by one tick and queues the result it must produce.
  function void note_tick(ibd_pkg::tick_t t);
    logic [ibd_pkg::TimeW:0]    sum;
    logic [ibd_pkg::LevelW-1:0] goal;
    logic [ibd_pkg::LevelW-1:0] stride;
    ibd_pkg::result_t           r;
    if (t.activity) begin
      idle_ms = '0;
    end else begin
      sum     = {1'b0, idle_ms} +
                {{(ibd_pkg::TimeW + 1 - ibd_pkg::ElapsedW){1'b0}}, t.elapsed_ms};
      idle_ms = sum[ibd_pkg::TimeW] ? '1 : sum[ibd_pkg::TimeW-1:0];
    end
    // The dim compare is checked first, so a sleep timeout below the dim
    // timeout only matters once the dim timeout has been reached.
    if (idle_ms < regs.dim_timeout) begin
      r.dimmed = 1'b0;
      goal     = regs.user_level;
    end else if (idle_ms < regs.sleep_timeout || t.playing) begin
      r.dimmed = 1'b1;
      goal     = regs.dim_level;
    end else begin
      r.dimmed = 1'b1;
      goal     = '0;
    end
    r.changed = 1'b0;
    if (!synced) begin
      synced    = 1'b1;
      backlight = regs.user_level;
      r.changed = 1'b1;
    end else if (backlight != goal) begin
      r.changed = 1'b1;
      if (backlight > goal) begin
        stride    = (regs.step_down == 0) ? 8'd1 : regs.step_down;
        backlight = (backlight - goal > stride) ? backlight - stride : goal;
      end else begin
        stride    = (regs.step_up == 0) ? 8'd1 : regs.step_up;
        backlight = (goal - backlight > stride) ? backlight + stride : goal;
      end
    end
    r.level = backlight;
    awaited.push_back(r);
  endfunction

  function void check_result(ibd_pkg::result_t got);
    ibd_pkg::result_t want;
    if (awaited.size() == 0) begin
      $display("%0t result with nothing expected: level %0d dimmed %0d changed %0d",
               $time, got.level, got.dimmed, got.changed);
      errors++;
      return;
    end
    want = awaited.pop_front();
    checked++;
    if (want.dimmed) dim_seen++;
    if (want.changed) change_seen++;
    if (got.level !== want.level) begin
      $display("%0t level mismatch: expected %0d, actual %0d", $time, want.level, got.level);
      errors++;
    end
    if (got.dimmed !== want.dimmed) begin
      $display("%0t dimmed mismatch: expected %0b, actual %0b", $time, want.dimmed,
               got.dimmed);
      errors++;
    end
    if (got.changed !== want.changed) begin
      $display("%0t changed mismatch: expected %0b, actual %0b", $time, want.changed,
               got.changed);
      errors++;
    end
  endfunction
endclass

module idle_backlight_dimmer_core_test;

  // Length of the long receiver hold-off that forces the block to back up.
  localparam int unsigned HoldCycles = 300;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      tick_valid;
  logic                      tick_ready;
  ibd_pkg::tick_t            tick;
  logic                      result_valid;
  logic                      result_ready;
  ibd_pkg::result_t          result;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [ibd_pkg::AddrW-1:0] paddr;
  logic [ibd_pkg::DataW-1:0] pwdata;
  logic [ibd_pkg::DataW-1:0] prdata;
  logic                      pready;

  backlight_scoreboard sb;

  // Per-cycle chance, in percent, that the sender idles or the receiver stalls.
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit          hold_request;
  int unsigned hold_count;
  int unsigned tick_count;
  int unsigned settings_count;

  idle_backlight_dimmer_core dut (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_ready   (tick_ready),
    .tick         (tick),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic ibd_pkg::tick_t tick_of(bit act, int unsigned ms, bit play);
    ibd_pkg::tick_t t;
    t.activity   = act;
    t.elapsed_ms = ms[ibd_pkg::ElapsedW-1:0];
    t.playing    = play;
    return t;
  endfunction

  function automatic ibd_pkg::cfg_t settings_of(int unsigned user, int unsigned dim_to,
                                                int unsigned sleep_to, int unsigned dim_lvl,
                                                int unsigned down, int unsigned up);
    ibd_pkg::cfg_t c;
    c.user_level    = user[ibd_pkg::LevelW-1:0];
    c.dim_timeout   = dim_to;
    c.sleep_timeout = sleep_to;
    c.dim_level     = dim_lvl[ibd_pkg::LevelW-1:0];
    c.step_down     = down[ibd_pkg::LevelW-1:0];
    c.step_up       = up[ibd_pkg::LevelW-1:0];
    return c;
  endfunction

  // Random register values lean on the extremes; timeouts are mostly kept
  // small so that a few dozen quiet ticks are enough to dim and to sleep.
  function automatic int unsigned pick_level();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic int unsigned pick_timeout();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom_range(0, 8000);
    endcase
  endfunction

  function automatic int unsigned pick_step();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 255;
      2:       return 1;
      default: return $urandom_range(1, 16);
    endcase
  endfunction

  // Offers one item, called at a rising edge. Valid stays high from the
  // previous item unless the sender decides to idle first. Ready is looked at
  // on the falling edge, where it is settled; if it is high there, the next
  // rising edge takes the item.
  task automatic offer_tick(input ibd_pkg::tick_t t);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      tick_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    tick_valid <= 1'b1;
    tick       <= t;
    @(negedge clk);
    while (!tick_ready) @(negedge clk);
    @(posedge clk);
    sb.note_tick(t);
    tick_count++;
  endtask

  // One APB write: setup phase, access phase, then psel is driven low again so
  // that back-to-back writes never drive psel twice in one step.
  task automatic write_reg(input ibd_pkg::reg_idx_t idx,
                           input logic [ibd_pkg::DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  // Registers may only change with no tick in flight: stop offering, wait for
  // every expected result, let the pipeline drain, then write.
  task automatic apply_settings(input ibd_pkg::cfg_t c);
    tick_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    write_reg(ibd_pkg::REG_USER_LEVEL,    ibd_pkg::DataW'(c.user_level));
    write_reg(ibd_pkg::REG_DIM_TIMEOUT,   c.dim_timeout);
    write_reg(ibd_pkg::REG_SLEEP_TIMEOUT, c.sleep_timeout);
    write_reg(ibd_pkg::REG_DIM_LEVEL,     ibd_pkg::DataW'(c.dim_level));
    write_reg(ibd_pkg::REG_STEP_DOWN,     ibd_pkg::DataW'(c.step_down));
    write_reg(ibd_pkg::REG_STEP_UP,       ibd_pkg::DataW'(c.step_up));
    settings_count++;
  endtask

  // Most random items form idle sessions: a run of quiet ticks that lets the
  // counter climb through the dim and sleep thresholds, closed by an activity
  // tick. Playback toggles now and then between sessions. About one item in
  // ten is plain noise with every field random.
  task automatic random_ticks(input int unsigned count);
    int unsigned    quiet;
    bit             play;
    ibd_pkg::tick_t t;
    quiet = $urandom_range(0, 20);
    play  = 1'($urandom_range(0, 1));
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) begin
        t.activity   = 1'($urandom_range(0, 1));
        t.elapsed_ms = ibd_pkg::ElapsedW'($urandom_range(0, 1023));
        t.playing    = 1'($urandom_range(0, 1));
      end else if (quiet == 0) begin
        t     = tick_of(1'b1, $urandom_range(0, 1023), play);
        quiet = $urandom_range(0, 30);
        if ($urandom_range(0, 2) == 0) play = !play;
      end else begin
        quiet--;
        // Short steps now and then land the counter right at a threshold.
        t = tick_of(1'b0, ($urandom_range(0, 2) == 0) ? $urandom_range(0, 20)
                                                     : $urandom_range(0, 1023), play);
      end
      offer_tick(t);
    end
  endtask

  // Receiver: ready changes only at rising edges. On request it holds ready low
  // for a long stretch while the sender keeps offering, so that the result and
  // input registers both fill and tick_ready has to drop.
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_count++;
        result_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      result_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Results are taken on the falling edge before the rising edge that
  // accepts them; valid, ready and the payload are all settled there.
  always @(negedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_result(result);
  end

  initial begin : stimulus
    rst            = 1'b1;
    tick_valid     = 1'b0;
    tick           = '0;
    result_ready   = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    hold_request   = 1'b0;
    hold_count     = 0;
    tick_count     = 0;
    settings_count = 0;
    send_idle_pct  = 8;
    stall_pct      = 51;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings. The first tick loads the user level outright; the second
    // finds the level already on target and must not report a change.
    offer_tick(tick_of(1'b0, 0, 1'b0));
    offer_tick(tick_of(1'b0, 0, 1'b0));
    offer_tick(tick_of(1'b1, 1023, 1'b1));
    offer_tick(tick_of(1'b0, 1023, 1'b0));

    // Zero step down behaves as a step of one; a full step up jumps at once.
    // Also walks through playback past the sleep timeout, real sleep, and the
    // counter sitting one below and exactly on the dim timeout.
    apply_settings(settings_of(255, 1000, 2000, 0, 0, 255));
    offer_tick(tick_of(1'b0, 1023, 1'b0));
    offer_tick(tick_of(1'b0, 1023, 1'b1));
    offer_tick(tick_of(1'b0, 1023, 1'b0));
    offer_tick(tick_of(1'b1, 0, 1'b0));
    offer_tick(tick_of(1'b0, 999, 1'b0));
    offer_tick(tick_of(1'b0, 1, 1'b0));

    // Sleep timeout below the dim timeout: user level until the dim timeout,
    // then straight to off unless playing. Step up of one makes a slow rise.
    apply_settings(settings_of(0, 500, 100, 255, 255, 1));
    offer_tick(tick_of(1'b1, 0, 1'b0));
    offer_tick(tick_of(1'b0, 499, 1'b0));
    offer_tick(tick_of(1'b0, 1, 1'b0));
    offer_tick(tick_of(1'b0, 0, 1'b1));
    offer_tick(tick_of(1'b0, 0, 1'b1));
    offer_tick(tick_of(1'b0, 1023, 1'b1));

    // A zero dim timeout keeps the block dimmed even on activity; the largest
    // timeouts keep it from dimming until the idle counter saturates.
    apply_settings(settings_of(200, 0, 32'hFFFF_FFFF, 100, 7, 3));
    offer_tick(tick_of(1'b1, 512, 1'b0));
    offer_tick(tick_of(1'b0, 256, 1'b1));
    offer_tick(tick_of(1'b0, 1023, 1'b0));
    apply_settings(settings_of(255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 255, 255, 255));
    offer_tick(tick_of(1'b0, 1023, 1'b0));
    offer_tick(tick_of(1'b1, 1023, 1'b1));

    // Six random settings: two with a mostly busy sender and a slow receiver,
    // two the other way round, two with no idling at all. The first and the
    // fifth also get a long receiver hold-off.
    for (int phase = 0; phase < 6; phase++) begin
      send_idle_pct = (phase < 2) ? 8 : (phase < 4) ? 51 : 0;
      stall_pct     = (phase < 2) ? 51 : (phase < 4) ? 8 : 0;
      apply_settings(settings_of(pick_level(), pick_timeout(), pick_timeout(),
                                 pick_level(), pick_step(), pick_step()));
      if (phase == 0 || phase == 4) hold_request = 1'b1;
      random_ticks(64);
    end

    tick_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // Anything the block sends after this point is a stray result.
    repeat (10) @(posedge clk);

    $display("Checked %0d results from %0d ticks under %0d register settings.",
             sb.checked, tick_count, settings_count + 1);
    $display("Of those %0d were dimmed and %0d moved the level; %0d long receiver holds.",
             sb.dim_seen, sb.change_seen, hold_count);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Roughly a hundred times the slowest expected run.
  initial begin : watchdog
    #2_000_000;
    $display("Run did not finish in time, %0d results still expected.", sb.pending());
    $display("tb: failure");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ibd_pkg.sv
rtl/ibd_regs.sv
rtl/idle_backlight_dimmer_core.sv
verif/idle_backlight_dimmer_core_test.sv
